// ----- sv/mqsb_pkg.sv -----
// Shared types and constants for the multi-queue shared buffer.
`timescale 1ns / 1ps
`default_nettype none
package mqsb_pkg;

  localparam int MODE_W = 1;
  localparam int QID_W  = 3;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_PUSH = 1'b0;
  localparam logic [MODE_W-1:0] MODE_POP  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic fetch;
    logic update;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic refuse;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- sv/mqsb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mqsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- sv/mqsb_ctrl.sv -----
// Sequencing state machine for the multi-queue shared buffer.
`timescale 1ns / 1ps
`default_nettype none
module mqsb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire mqsb_pkg::dp_stat_t stat,
  output mqsb_pkg::cmd_t          cmd,
  output logic                    busy
);
  import mqsb_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        // refused op touches no pointer: go straight to the result
        state_nxt = stat.refuse ? ST_FINISH : ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/mqsb_dp.sv -----
// Datapath: pointer registers, link/data/head/tail stores and result registers.
`timescale 1ns / 1ps
`default_nettype none
module mqsb_dp #(
  parameter int ENTRIES    = 256,
  parameter int QUEUES     = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire mqsb_pkg::cmd_t                    cmd,
  output mqsb_pkg::dp_stat_t                     stat,
  input  wire logic [mqsb_pkg::MODE_W-1:0]       in_mode,
  input  wire logic [mqsb_pkg::QID_W-1:0]        in_queue_id,
  input  wire logic signed [mqsb_pkg::VAL_W-1:0] in_value,
  output logic                                   out_valid,
  output logic [mqsb_pkg::STAT_W-1:0]            out_status,
  output logic signed [mqsb_pkg::VAL_W-1:0]      out_data_out
);
  import mqsb_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int PW = $clog2(ENTRIES + 1);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);
  localparam logic [8:0]    QN  = 9'(QUEUES);

  // queue number modulo QUEUES on a 3-bit value
  function automatic logic [QW-1:0] qmod(input logic [QID_W-1:0] id);
    logic [8:0] v;
    v = 9'(id);
    for (int i = 0; i < 8; i++) begin
      if (v >= QN) begin
        v = v - QN;
      end
    end
    return v[QW-1:0];
  endfunction

  logic [MODE_W-1:0]     mode_r;
  logic [QW-1:0]         q_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [PW-1:0]         slot_r;
  logic [PW-1:0]         head_cur_r;
  logic [PW-1:0]         tail_r;
  logic                  refuse_r;
  logic [PW-1:0]         free_head_r;
  logic [PW-1:0]         wm_r;        // entries at or above this still hold reset links
  logic [QUEUES-1:0]     head_vld_r;
  logic [VAL_W-1:0]      data_hold_r;
  logic                  out_valid_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [VAL_W-1:0]      out_data_r;

  logic [63:0]           value_x;
  logic [QW-1:0]         q_in;
  logic [PW-1:0]         head_rd, tail_rd, link_rd, link_eff;
  logic [DATA_WIDTH-1:0] data_rd;
  logic [63:0]           data_x;
  logic [PW-1:0]         head_cur, slot_sel;
  logic                  is_push;

  logic                  head_we, tail_we, link_we, data_we;
  logic [PW-1:0]         head_wd, link_wd;
  logic [PW-1:0]         link_wa;

  assign value_x = 64'($unsigned(in_value));
  assign q_in    = qmod(in_queue_id);
  assign is_push = (mode_r == MODE_PUSH);

  // fetch step
  assign head_cur    = head_vld_r[q_r] ? head_rd : NIL;
  assign slot_sel    = is_push ? free_head_r : head_cur;
  assign stat.refuse = (slot_sel == NIL);

  // untouched entries keep their reset link i+1
  assign link_eff = (slot_r >= wm_r) ? slot_r + PW'(1) : link_rd;
  assign data_x   = 64'(data_rd);

  always_comb begin
    head_we = 1'b0;
    head_wd = slot_r;
    tail_we = 1'b0;
    data_we = 1'b0;
    link_we = 1'b0;
    link_wa = slot_r;
    link_wd = NIL;
    if (cmd.update) begin
      if (is_push) begin
        tail_we = 1'b1;
        data_we = 1'b1;
        if (head_cur_r == NIL) begin
          head_we = 1'b1;
        end else if (tail_r != NIL) begin
          link_we = 1'b1;
          link_wa = tail_r;
          link_wd = slot_r;
        end
      end else begin
        head_we = 1'b1;
        head_wd = link_eff;
        link_we = 1'b1;
        link_wd = free_head_r;
      end
    end else if (cmd.finish && is_push && !refuse_r) begin
      link_we = 1'b1;
    end
  end

  mqsb_ram #(.WIDTH(PW), .DEPTH(QUEUES), .AW(QW)) u_head_ram (
    .clk     (clk),
    .wr_en   (head_we),
    .wr_addr (q_r),
    .wr_data (head_wd),
    .rd_addr (q_in),
    .rd_data (head_rd)
  );

  mqsb_ram #(.WIDTH(PW), .DEPTH(QUEUES), .AW(QW)) u_tail_ram (
    .clk     (clk),
    .wr_en   (tail_we),
    .wr_addr (q_r),
    .wr_data (slot_r),
    .rd_addr (q_in),
    .rd_data (tail_rd)
  );

  mqsb_ram #(.WIDTH(PW), .DEPTH(ENTRIES), .AW(AW)) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_wa[AW-1:0]),
    .wr_data (link_wd),
    .rd_addr (slot_sel[AW-1:0]),
    .rd_data (link_rd)
  );

  mqsb_ram #(.WIDTH(DATA_WIDTH), .DEPTH(ENTRIES), .AW(AW)) u_data_ram (
    .clk     (clk),
    .wr_en   (data_we),
    .wr_addr (slot_r[AW-1:0]),
    .wr_data (value_r),
    .rd_addr (slot_sel[AW-1:0]),
    .rd_data (data_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      wm_r        <= '0;
      head_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (link_we && (link_wa == wm_r)) begin
        wm_r <= wm_r + PW'(1);
      end
      if (cmd.update) begin
        free_head_r <= is_push ? link_eff : slot_r;
        if (is_push && (head_cur_r == NIL)) begin
          head_vld_r[q_r] <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      q_r     <= q_in;
      value_r <= value_x[DATA_WIDTH-1:0];
    end
    if (cmd.fetch) begin
      slot_r     <= slot_sel;
      head_cur_r <= head_cur;
      tail_r     <= tail_rd;
      refuse_r   <= stat.refuse;
    end
    if (cmd.update) begin
      data_hold_r <= data_x[VAL_W-1:0];
    end
    if (cmd.finish) begin
      if (refuse_r) begin
        out_status_r <= is_push ? STAT_FULL : STAT_EMPTY;
      end else begin
        out_status_r <= STAT_DONE;
      end
      out_data_r <= (!is_push && !refuse_r) ? data_hold_r : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data_out = $signed(out_data_r);

endmodule
`default_nettype wire

// ----- sv/multi_queue_shared_buffer_core.sv -----
// Top level of the multi-queue shared buffer: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// Several FIFO queues share one entry store. Each queue is a linked list
// through a link RAM; unused entries sit on a free list.
//
// Input: drive in_mode (0 push, 1 pop), in_queue_id and in_value and raise
//   start. The word is taken at a rising edge with start high and busy low.
//   in_queue_id is reduced modulo QUEUES; in_value is ignored on pop.
// Output: one result word per input, shown for one cycle with out_valid high.
//   out_status: 0 done, 1 push refused (store full), 2 pop refused (empty).
//   out_data_out: popped word on a good pop, zero otherwise.
//   The receiver cannot stall; the result must be taken when shown.
// Timing: an accepted word walks fetch, update and finish steps (a refused op
//   skips update); busy drops in the cycle the result is shown, so a new word
//   can start then, but not while the last one is still in its steps. The
//   pace is set by the single link RAM: its registered read of the next link
//   comes first, then two link writes (tail link and new-entry terminator) go
//   through its one write port in turn.
// Reset: queues empty, free list 0,1,...,ENTRIES-1. The link RAM gets no
//   clearing pass: a watermark marks entries never written, and those read as
//   their reset link, so the block is ready right after reset.
module multi_queue_shared_buffer_core #(
  parameter int ENTRIES    = 256,
  parameter int QUEUES     = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [mqsb_pkg::MODE_W-1:0]       in_mode,
  input  wire logic [mqsb_pkg::QID_W-1:0]        in_queue_id,
  input  wire logic signed [mqsb_pkg::VAL_W-1:0] in_value,
  output logic                                   out_valid,
  output logic [mqsb_pkg::STAT_W-1:0]            out_status,
  output logic signed [mqsb_pkg::VAL_W-1:0]      out_data_out
);
  import mqsb_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  // sequencing: idle -> fetch -> update -> finish (update skipped when refused)
  mqsb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // stores, pointers and result registers
  mqsb_dp #(
    .ENTRIES    (ENTRIES),
    .QUEUES     (QUEUES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_mode      (in_mode),
    .in_queue_id  (in_queue_id),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_data_out (out_data_out)
  );

endmodule
`default_nettype wire
